// ===== design/tvwe_pkg.sv =====
// tvwe_pkg: widths, register codes and the quarter-wave sine table of the tone voice
// no dependencies; imported by every other file of the block

package tvwe_pkg;

    localparam int COUNT_BITS       = 20;
    localparam int PHASE_BITS       = 32;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int MIX_BITS      = 20;
    localparam int PCM_BITS      = 16;
    localparam int STEP_BITS     = 31;
    localparam int AMP_BITS      = 16;
    localparam int LEN_BITS      = 20;
    localparam int RAMP_BITS     = 16;
    localparam int ENV_BITS      = 17;
    localparam int MAG_BITS      = 17;
    localparam int PROD_BITS     = 2 * MAG_BITS;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam int CMP_BITS      = ((COUNT_BITS > LEN_BITS) ? COUNT_BITS : LEN_BITS) + 1;
    localparam int SINE_IDX_BITS = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int IDX_PROD_BITS = PHASE_BITS - 2 + SINE_IDX_BITS;

    localparam int DIV_STEPS     = RAMP_BITS;
    localparam int DIV_CNT_BITS  = $clog2(DIV_STEPS);

    localparam logic [ENV_BITS-1:0] ENV_ONE    = ENV_BITS'(65536);
    localparam logic [MAG_BITS-1:0] MAG_ONE    = MAG_BITS'(32768);
    localparam logic [MAG_BITS-1:0] PCM_SCALE  = MAG_BITS'(32000);
    localparam logic signed [MIX_BITS-1:0] MIX_MAX = {1'b0, {(MIX_BITS-1){1'b1}}};
    localparam logic signed [MIX_BITS-1:0] MIX_MIN = {1'b1, {(MIX_BITS-1){1'b0}}};

    localparam logic [RAMP_BITS-1:0] ATTACK_RESET  = RAMP_BITS'(220);
    localparam logic [RAMP_BITS-1:0] RELEASE_RESET = RAMP_BITS'(661);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_PHASE_STEP  = 3'd0,
        CFG_AMPLITUDE   = 3'd1,
        CFG_WAVE_SQUARE = 3'd2,
        CFG_TONE_LENGTH = 3'd3,
        CFG_ATTACK_LEN  = 3'd4,
        CFG_RELEASE_LEN = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic                 start;
        logic [RAMP_BITS-1:0] num;
        logic [RAMP_BITS-1:0] den;
    } div_req_t;

    typedef logic [MAG_BITS-1:0] sine_tab_t [0:SINE_TABLE_DEPTH];

    localparam logic [63:0] Q30_ONE     = 64'd1073741824;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // sin(pi/2 * k / depth) in q1.15, horner series in q30
    function automatic sine_tab_t build_sine_table();
        sine_tab_t   tab;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] h;
        logic [63:0] s;
        logic [63:0] q;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            x  = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
            x2 = (x * x) >> 30;
            h  = Q30_ONE - x2 / 72;
            h  = Q30_ONE - ((x2 * h) >> 30) / 42;
            h  = Q30_ONE - ((x2 * h) >> 30) / 20;
            h  = Q30_ONE - ((x2 * h) >> 30) / 6;
            s  = (x * h) >> 30;
            q  = (s + 64'd16384) >> 15;
            if (q > 64'd32768)
            begin
                q = 64'd32768;
            end
            tab[k] = MAG_BITS'(q);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TABLE = build_sine_table();

endpackage

// ===== design/tvwe_if.sv =====
// tvwe_if: valid/ready channels of the tone voice (sample in, sample out, register write)
// depends on tvwe_pkg for field widths

interface tvwe_in_if import tvwe_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [MIX_BITS-1:0] mix_in;
    logic                       start_tone;

    modport source (output valid, output mix_in, output start_tone, input ready);
    modport sink (input valid, input mix_in, input start_tone, output ready);
endinterface

interface tvwe_out_if import tvwe_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [MIX_BITS-1:0] mix_out;
    logic signed [PCM_BITS-1:0] pcm_sample;
    logic                       voice_active;

    modport source (output valid, output mix_out, output pcm_sample, output voice_active,
                    input ready);
    modport sink (input valid, input mix_out, input pcm_sample, input voice_active,
                  output ready);
endinterface

interface tvwe_cfg_if import tvwe_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/tvwe_div.sv =====
// tvwe_div: restoring divider, one quotient bit per cycle, num < den
// gives floor(num * 2^16 / den); depends on tvwe_pkg

module tvwe_div import tvwe_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_req_t             req,
    output logic                 done,
    output logic [RAMP_BITS-1:0] quotient
);

    logic [RAMP_BITS:0]      rem_reg;
    logic [RAMP_BITS:0]      rem_next;
    logic [RAMP_BITS-1:0]    den_reg;
    logic [RAMP_BITS-1:0]    quo_reg;
    logic [RAMP_BITS-1:0]    quo_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg;
    logic [DIV_CNT_BITS-1:0] cnt_next;
    logic                    busy_reg;
    logic                    busy_next;
    logic                    done_reg;
    logic                    done_next;
    logic [RAMP_BITS:0]      rem_dbl;
    logic                    bit_ge;

    always_comb
    begin
        rem_dbl   = {rem_reg[RAMP_BITS-1:0], 1'b0};
        bit_ge    = rem_dbl >= {1'b0, den_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = {1'b0, req.num};
            quo_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = bit_ge ? (rem_dbl - {1'b0, den_reg}) : rem_dbl;
            quo_next = {quo_reg[RAMP_BITS-2:0], bit_ge};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_BITS'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/tvwe_mul.sv =====
// tvwe_mul: shared unsigned 17 x 17 multiplier with registered product
// depends on tvwe_pkg; product holds while en is low

module tvwe_mul import tvwe_pkg::*; (
    input  logic                 clk,
    input  logic                 en,
    input  logic [MAG_BITS-1:0]  a,
    input  logic [MAG_BITS-1:0]  b,
    output logic [PROD_BITS-1:0] p
);

    logic [PROD_BITS-1:0] p_reg;
    logic [PROD_BITS-1:0] p_next;

    always_comb
    begin
        p_next = en ? (PROD_BITS'(a) * PROD_BITS'(b)) : p_reg;
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// ===== design/tone_voice_with_envelope.sv =====
// tone_voice_with_envelope: one voice, a sequencer around a shared multiplier and divider
// states in order: idle, setup, div (only while an envelope ramp runs), gain, scale, add, pcm, done
// an idle voice goes from setup to pcm; one item at a time; the 16-step divider runs in div
// reset: registers return to defaults, sample count to all ones (voice idle), phase to zero
// depends on tvwe_pkg, tvwe_if, tvwe_div, tvwe_mul

module tone_voice_with_envelope import tvwe_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    tvwe_in_if.sink     sample_in,
    tvwe_out_if.source  sample_out,
    tvwe_cfg_if.sink    cfg
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b00000001,
        ST_SETUP = 8'b00000010,
        ST_DIV   = 8'b00000100,
        ST_GAIN  = 8'b00001000,
        ST_SCALE = 8'b00010000,
        ST_ADD   = 8'b00100000,
        ST_PCM   = 8'b01000000,
        ST_DONE  = 8'b10000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [STEP_BITS-1:0]       phase_step_reg, phase_step_next;
    logic [AMP_BITS-1:0]        amplitude_reg, amplitude_next;
    logic                       wave_square_reg, wave_square_next;
    logic [LEN_BITS-1:0]        tone_length_reg, tone_length_next;
    logic [RAMP_BITS-1:0]       attack_len_reg, attack_len_next;
    logic [RAMP_BITS-1:0]       release_len_reg, release_len_next;
    logic [COUNT_BITS-1:0]      count_reg, count_next;
    logic [PHASE_BITS-1:0]      phase_reg, phase_next;
    logic                       out_valid_reg, out_valid_next;

    logic signed [MIX_BITS-1:0] mix_reg, mix_next;
    logic                       active_reg, active_next;
    logic [ENV_BITS-1:0]        env_reg, env_next;
    logic [MAG_BITS-1:0]        osc_mag_reg, osc_mag_next;
    logic                       osc_neg_reg, osc_neg_next;
    logic                       pcm_neg_reg, pcm_neg_next;
    logic signed [MIX_BITS-1:0] mix_out_reg, mix_out_next;
    logic signed [PCM_BITS-1:0] pcm_reg, pcm_next;
    logic                       voice_active_reg, voice_active_next;

    div_req_t                   div_req;
    logic                       div_done;
    logic [RAMP_BITS-1:0]       div_quo;
    logic                       mul_en;
    logic [MAG_BITS-1:0]        mul_a;
    logic [MAG_BITS-1:0]        mul_b;
    logic [PROD_BITS-1:0]       mul_p;

    logic [1:0]                 quad;
    logic [PHASE_BITS-3:0]      frac;
    logic [IDX_PROD_BITS-1:0]   idx_prod;
    logic [SINE_IDX_BITS-1:0]   idx;
    logic [SINE_IDX_BITS-1:0]   sine_addr;
    logic                       is_active;
    logic                       in_attack;
    logic                       in_release;
    logic [CMP_BITS-1:0]        count_ext;
    logic [CMP_BITS-1:0]        tone_ext;
    logic [MAG_BITS-1:0]        voice_mag;
    logic signed [MIX_BITS:0]   mix_sum;
    logic signed [MIX_BITS:0]   mix_neg;
    logic [MAG_BITS-1:0]        clamp_mag;
    logic [PCM_BITS-1:0]        pcm_mag;
    logic [31:0]                phase_sum;

    tvwe_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quo)
    );

    tvwe_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // phase to table address, envelope region
    always_comb
    begin
        quad     = phase_reg[PHASE_BITS-1:PHASE_BITS-2];
        frac     = phase_reg[PHASE_BITS-3:0];
        idx_prod = IDX_PROD_BITS'(frac) * IDX_PROD_BITS'(SINE_TABLE_DEPTH);
        idx      = idx_prod[IDX_PROD_BITS-1 -: SINE_IDX_BITS];
        if (idx > SINE_IDX_BITS'(SINE_TABLE_DEPTH))
        begin
            idx = SINE_IDX_BITS'(SINE_TABLE_DEPTH);
        end
        sine_addr  = quad[0] ? (SINE_IDX_BITS'(SINE_TABLE_DEPTH) - idx) : idx;
        count_ext  = CMP_BITS'(count_reg);
        tone_ext   = CMP_BITS'(tone_length_reg);
        is_active  = count_ext < tone_ext;
        in_attack  = (attack_len_reg != '0) && (count_ext < CMP_BITS'(attack_len_reg));
        in_release = (release_len_reg != '0)
                     && ((count_ext + CMP_BITS'(release_len_reg)) > tone_ext)
                     && is_active;
        phase_sum  = 32'(phase_reg) + 32'(phase_step_reg);
    end

    // mix update and pcm clamp
    always_comb
    begin
        voice_mag = mul_p[MAG_BITS+14:15];
        mix_sum   = (MIX_BITS+1)'(mix_reg)
                    + (osc_neg_reg ? -$signed({4'b0, voice_mag})
                                   : $signed({4'b0, voice_mag}));
        mix_neg   = -((MIX_BITS+1)'(mix_reg));
        if (mix_reg >= 0)
        begin
            clamp_mag = ($signed(mix_reg) > $signed(MIX_BITS'(32768)))
                        ? MAG_ONE : mix_reg[MAG_BITS-1:0];
        end
        else
        begin
            clamp_mag = (mix_neg > $signed((MIX_BITS+1)'(32768)))
                        ? MAG_ONE : mix_neg[MAG_BITS-1:0];
        end
        pcm_mag = mul_p[PCM_BITS+14:15];
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_step_next   = phase_step_reg;
        amplitude_next    = amplitude_reg;
        wave_square_next  = wave_square_reg;
        tone_length_next  = tone_length_reg;
        attack_len_next   = attack_len_reg;
        release_len_next  = release_len_reg;
        count_next        = count_reg;
        phase_next        = phase_reg;
        out_valid_next    = out_valid_reg;
        mix_next          = mix_reg;
        active_next       = active_reg;
        env_next          = env_reg;
        osc_mag_next      = osc_mag_reg;
        osc_neg_next      = osc_neg_reg;
        pcm_neg_next      = pcm_neg_reg;
        mix_out_next      = mix_out_reg;
        pcm_next          = pcm_reg;
        voice_active_next = voice_active_reg;
        div_req           = '0;
        mul_en            = 1'b0;
        mul_a             = '0;
        mul_b             = '0;

        if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_PHASE_STEP:  phase_step_next  = cfg.data[STEP_BITS-1:0];
                CFG_AMPLITUDE:   amplitude_next   = cfg.data[AMP_BITS-1:0];
                CFG_WAVE_SQUARE: wave_square_next = cfg.data[0];
                CFG_TONE_LENGTH: tone_length_next = cfg.data[LEN_BITS-1:0];
                CFG_ATTACK_LEN:  attack_len_next  = cfg.data[RAMP_BITS-1:0];
                CFG_RELEASE_LEN: release_len_next = cfg.data[RAMP_BITS-1:0];
                default: ;
            endcase
        end

        if (out_valid_reg && sample_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_in.valid)
                begin
                    mix_next = sample_in.mix_in;
                    if (sample_in.start_tone)
                    begin
                        count_next = '0;
                        phase_next = '0;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                active_next = is_active;
                if (wave_square_reg)
                begin
                    osc_mag_next = MAG_ONE;
                end
                else
                begin
                    osc_mag_next = SINE_TABLE[sine_addr];
                end
                osc_neg_next = quad[1];
                if (!is_active)
                begin
                    state_next = ST_PCM;
                end
                else if (in_attack)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = RAMP_BITS'(count_reg);
                    div_req.den   = attack_len_reg;
                    state_next    = ST_DIV;
                end
                else if (in_release)
                begin
                    div_req.start = 1'b1;
                    div_req.num   = RAMP_BITS'(tone_ext - count_ext);
                    div_req.den   = release_len_reg;
                    state_next    = ST_DIV;
                end
                else
                begin
                    env_next   = ENV_ONE;
                    state_next = ST_GAIN;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    env_next   = {1'b0, div_quo};
                    state_next = ST_GAIN;
                end
            end
            ST_GAIN:
            begin
                mul_en     = 1'b1;
                mul_a      = MAG_BITS'(amplitude_reg);
                mul_b      = env_reg;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                mul_en     = 1'b1;
                mul_a      = MAG_BITS'(mul_p[31:16]);
                mul_b      = osc_mag_reg;
                state_next = ST_ADD;
            end
            ST_ADD:
            begin
                if (mix_sum > (MIX_BITS+1)'(MIX_MAX))
                begin
                    mix_next = MIX_MAX;
                end
                else if (mix_sum < (MIX_BITS+1)'(MIX_MIN))
                begin
                    mix_next = MIX_MIN;
                end
                else
                begin
                    mix_next = mix_sum[MIX_BITS-1:0];
                end
                if (count_reg != '1)
                begin
                    count_next = count_reg + 1'b1;
                end
                phase_next = PHASE_BITS'(phase_sum);
                state_next = ST_PCM;
            end
            ST_PCM:
            begin
                mul_en       = 1'b1;
                mul_a        = clamp_mag;
                mul_b        = PCM_SCALE;
                pcm_neg_next = mix_reg < 0;
                state_next   = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || sample_out.ready)
                begin
                    mix_out_next      = mix_reg;
                    pcm_next          = pcm_neg_reg ? -$signed(pcm_mag) : $signed(pcm_mag);
                    voice_active_next = active_reg;
                    out_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_step_reg  <= '0;
            amplitude_reg   <= '0;
            wave_square_reg <= 1'b0;
            tone_length_reg <= '0;
            attack_len_reg  <= ATTACK_RESET;
            release_len_reg <= RELEASE_RESET;
            count_reg       <= '1;
            phase_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_step_reg  <= phase_step_next;
            amplitude_reg   <= amplitude_next;
            wave_square_reg <= wave_square_next;
            tone_length_reg <= tone_length_next;
            attack_len_reg  <= attack_len_next;
            release_len_reg <= release_len_next;
            count_reg       <= count_next;
            phase_reg       <= phase_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mix_reg          <= mix_next;
        active_reg       <= active_next;
        env_reg          <= env_next;
        osc_mag_reg      <= osc_mag_next;
        osc_neg_reg      <= osc_neg_next;
        pcm_neg_reg      <= pcm_neg_next;
        mix_out_reg      <= mix_out_next;
        pcm_reg          <= pcm_next;
        voice_active_reg <= voice_active_next;
    end

    assign sample_in.ready         = state_reg == ST_IDLE;
    assign cfg.ready               = 1'b1;
    assign sample_out.valid        = out_valid_reg;
    assign sample_out.mix_out      = mix_out_reg;
    assign sample_out.pcm_sample   = pcm_reg;
    assign sample_out.voice_active = voice_active_reg;

endmodule

// ===== design/tvwe_checker.sv =====
// tvwe_checker: port-level assertions for the tone voice, bound to the top level
// depends on tvwe_pkg and tone_voice_with_envelope

module tvwe_checker import tvwe_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic signed [MIX_BITS-1:0] mix_out,
    input logic signed [PCM_BITS-1:0] pcm_sample,
    input logic                       voice_active
);

    // result held until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(mix_out) && $stable(pcm_sample)
                                    && $stable(voice_active))
        else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while an item is in progress");

    // pcm within range and never of the opposite sign to the mix
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pcm_sample <= 16'sd32000) && (pcm_sample >= -16'sd32000)
                      && !((pcm_sample < 0) && (mix_out >= 0))
                      && !((pcm_sample > 0) && (mix_out <= 0)))
        else $error("pcm sample out of range or of wrong sign");

endmodule

bind tone_voice_with_envelope tvwe_checker u_tvwe_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (sample_in.valid),
    .in_ready     (sample_in.ready),
    .out_valid    (sample_out.valid),
    .out_ready    (sample_out.ready),
    .mix_out      (sample_out.mix_out),
    .pcm_sample   (sample_out.pcm_sample),
    .voice_active (sample_out.voice_active)
);

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// testbench: self-checking bench for tone_voice_with_envelope with its own voice predictor
// drives the sample and register channels, checks every output item in order
// depends on tvwe_pkg, tvwe_if and the design files

module testbench;
    import tvwe_pkg::*;

    localparam int N_DIRECTED     = 43;
    localparam int N_PHASES       = 8;
    localparam int PHASE_SAMPLES  = 100;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT        = 170;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam longint unsigned Q30_UNIT   = 64'd1073741824;
    localparam longint unsigned HALF_PI_30 = 64'd1686629713;

    typedef struct {
        logic signed [MIX_BITS-1:0] mix;
        logic signed [PCM_BITS-1:0] pcm;
        logic                       active;
    } voice_sample_t;

    typedef struct {
        bit                         is_reg;
        cfg_idx_t                   reg_idx;
        logic [CFG_DATA_BITS-1:0]   reg_data;
        logic signed [MIX_BITS-1:0] mix;
        logic                       start;
        bit                         known;
        voice_sample_t              want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    tvwe_in_if  sample_in_ch ();
    tvwe_out_if sample_out_ch ();
    tvwe_cfg_if cfg_ch ();

    tone_voice_with_envelope DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .sample_in  (sample_in_ch),
        .sample_out (sample_out_ch),
        .cfg        (cfg_ch)
    );

    // predictor state and register copies
    logic [STEP_BITS-1:0]  r_step;
    logic [AMP_BITS-1:0]   r_amp;
    logic                  r_square;
    logic [LEN_BITS-1:0]   r_len;
    logic [RAMP_BITS-1:0]  r_attack;
    logic [RAMP_BITS-1:0]  r_release;
    logic [COUNT_BITS-1:0] v_count;
    logic [PHASE_BITS-1:0] v_phase;
    int                    sine_q15 [0:SINE_TABLE_DEPTH];

    voice_sample_t pending_samples [$];
    int            fail_count;
    int            samples_sent;
    int            results_seen;
    int            active_seen;
    int            settings_used;
    int            stall_cycles;

    function automatic int quarter_sine(int k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned h;
        longint unsigned s;
        longint unsigned q;
        x  = (longint'(k) * HALF_PI_30) / SINE_TABLE_DEPTH;
        x2 = (x * x) >> 30;
        h  = Q30_UNIT - x2 / 72;
        h  = Q30_UNIT - ((x2 * h) >> 30) / 42;
        h  = Q30_UNIT - ((x2 * h) >> 30) / 20;
        h  = Q30_UNIT - ((x2 * h) >> 30) / 6;
        s  = (x * h) >> 30;
        q  = (s + 64'd16384) >> 15;
        if (q > 64'd32768)
        begin
            q = 64'd32768;
        end
        return int'(q);
    endfunction

    function automatic longint unsigned ramp_level(longint unsigned i);
        longint unsigned att;
        longint unsigned rel;
        longint unsigned len;
        att = r_attack;
        rel = r_release;
        len = r_len;
        if (att != 0 && i < att)
        begin
            return (i << 16) / att;
        end
        if (rel != 0 && i + rel > len && i < len)
        begin
            return ((len - i) << 16) / rel;
        end
        return 64'd65536;
    endfunction

    function automatic voice_sample_t mix_voice(logic signed [MIX_BITS-1:0] mix_in, logic start);
        voice_sample_t   r;
        longint          mix;
        longint          c;
        longint          v;
        longint          p;
        longint unsigned env;
        longint unsigned gain;
        longint unsigned mag;
        longint unsigned frac;
        longint unsigned idx;
        logic [1:0]      quad;
        int              osc;
        mix = mix_in;
        if (start)
        begin
            v_count = '0;
            v_phase = '0;
        end
        r.active = (v_count < r_len);
        if (r.active)
        begin
            env  = ramp_level(v_count);
            quad = v_phase[PHASE_BITS-1 -: 2];
            if (r_square)
            begin
                osc = quad[1] ? -32768 : 32768;
            end
            else
            begin
                frac = v_phase[PHASE_BITS-3:0];
                idx  = (frac * SINE_TABLE_DEPTH) >> (PHASE_BITS - 2);
                osc  = quad[0] ? sine_q15[SINE_TABLE_DEPTH - idx] : sine_q15[idx];
                if (quad[1])
                begin
                    osc = -osc;
                end
            end
            mag  = (osc < 0) ? -osc : osc;
            gain = (longint'(r_amp) * env) >> 16;
            v    = longint'((gain * mag) >> 15);
            mix  = mix + ((osc < 0) ? -v : v);
            if (mix > 524287)
            begin
                mix = 524287;
            end
            if (mix < -524288)
            begin
                mix = -524288;
            end
            if (v_count != '1)
            begin
                v_count = v_count + 1'b1;
            end
            v_phase = v_phase + PHASE_BITS'(r_step);
        end
        c = mix;
        if (c > 32768)
        begin
            c = 32768;
        end
        if (c < -32768)
        begin
            c = -32768;
        end
        p = (((c < 0) ? -c : c) * 32000) >> 15;
        if (c < 0)
        begin
            p = -p;
        end
        r.mix = MIX_BITS'(mix);
        r.pcm = PCM_BITS'(p);
        return r;
    endfunction

    function automatic void apply_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            CFG_PHASE_STEP:  r_step    = data[STEP_BITS-1:0];
            CFG_AMPLITUDE:   r_amp     = data[AMP_BITS-1:0];
            CFG_WAVE_SQUARE: r_square  = data[0];
            CFG_TONE_LENGTH: r_len     = data[LEN_BITS-1:0];
            CFG_ATTACK_LEN:  r_attack  = data[RAMP_BITS-1:0];
            CFG_RELEASE_LEN: r_release = data[RAMP_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic stim_row_t plain_sample(int mix, bit start);
        stim_row_t row;
        row.is_reg   = 1'b0;
        row.reg_idx  = CFG_PHASE_STEP;
        row.reg_data = '0;
        row.mix      = MIX_BITS'(mix);
        row.start    = start;
        row.known    = 1'b0;
        row.want     = '{mix: '0, pcm: '0, active: 1'b0};
        return row;
    endfunction

    function automatic stim_row_t known_sample(int mix, bit start, int w_mix, int w_pcm,
                                               bit w_act);
        stim_row_t row;
        row       = plain_sample(mix, start);
        row.known = 1'b1;
        row.want  = '{mix: MIX_BITS'(w_mix), pcm: PCM_BITS'(w_pcm), active: w_act};
        return row;
    endfunction

    function automatic stim_row_t reg_write(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
        stim_row_t row;
        row          = plain_sample(0, 1'b0);
        row.is_reg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        return row;
    endfunction

    task automatic send_sample(stim_row_t row);
        voice_sample_t predicted;
        int            gap;
        gap = (((samples_sent / 50) % 4) == 3) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            sample_in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample_in_ch.valid      <= 1'b1;
        sample_in_ch.mix_in     <= row.mix;
        sample_in_ch.start_tone <= row.start;
        do @(posedge clk); while (!sample_in_ch.ready);
        predicted = mix_voice(row.mix, row.start);
        pending_samples.push_back(row.known ? row.want : predicted);
        samples_sent++;
        @(negedge clk);
    endtask

    task automatic set_register(cfg_idx_t idx, logic [CFG_DATA_BITS-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        apply_register(idx, data);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        sample_in_ch.valid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic program_phase(int ph);
        logic [STEP_BITS-1:0] step;
        logic [AMP_BITS-1:0]  amp;
        logic [LEN_BITS-1:0]  len;
        logic [RAMP_BITS-1:0] att;
        logic [RAMP_BITS-1:0] rel;
        case (ph % 4)
            0:       step = '0;
            1:       step = '1;
            default: step = STEP_BITS'($urandom);
        endcase
        case (ph % 3)
            0:       amp = AMP_BITS'(32768);
            1:       amp = AMP_BITS'($urandom_range(32769, 65535));
            default: amp = AMP_BITS'($urandom);
        endcase
        if (ph == 5)
        begin
            amp = '0;
        end
        len = LEN_BITS'($urandom_range(1, 400));
        if (ph == 3)
        begin
            len = '0;
        end
        if (ph == 6)
        begin
            len = '1;
        end
        att = RAMP_BITS'($urandom_range(1, 150));
        rel = RAMP_BITS'($urandom_range(1, 150));
        if (ph == 2)
        begin
            att = '0;
            rel = '0;
        end
        if (ph == 4)
        begin
            att = '1;
            rel = RAMP_BITS'(1);
        end
        if (ph == 7)
        begin
            att = RAMP_BITS'(1);
            rel = '1;
        end
        // junk above each register's width must be dropped
        set_register(CFG_PHASE_STEP, {1'($urandom), step});
        set_register(CFG_AMPLITUDE, {16'($urandom), amp});
        set_register(CFG_WAVE_SQUARE, {31'($urandom), 1'(ph % 2)});
        set_register(CFG_TONE_LENGTH, {12'($urandom), len});
        set_register(CFG_ATTACK_LEN, {16'($urandom), att});
        set_register(CFG_RELEASE_LEN, {16'($urandom), rel});
        settings_used++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // output side: random stalls and one long hold-off
    initial
    begin : result_sink
        int  wait_cycles;
        bit  held;
        held                = 1'b0;
        sample_out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            wait_cycles = (((results_seen / 64) % 4) == 1) ? 0 : $urandom_range(0, 12);
            if (!held && results_seen >= HOLD_AT)
            begin
                held        = 1'b1;
                wait_cycles = HOLD_CYCLES;
            end
            if (wait_cycles > 0)
            begin
                sample_out_ch.ready <= 1'b0;
                repeat (wait_cycles) @(negedge clk);
            end
            sample_out_ch.ready <= 1'b1;
            do @(posedge clk); while (!sample_out_ch.valid);
        end
    end

    always @(posedge clk)
    begin
        voice_sample_t want;
        if (rst_n && sample_out_ch.valid && sample_out_ch.ready)
        begin
            results_seen++;
            if (sample_out_ch.voice_active)
            begin
                active_seen++;
            end
            if (pending_samples.size() == 0)
            begin
                $error("output item with nothing expected: mix_out %0d",
                       sample_out_ch.mix_out);
                fail_count++;
            end
            else
            begin
                want = pending_samples.pop_front();
                if (sample_out_ch.mix_out !== want.mix)
                begin
                    $error("mix_out: expected %0d, got %0d", want.mix, sample_out_ch.mix_out);
                    fail_count++;
                end
                if (sample_out_ch.pcm_sample !== want.pcm)
                begin
                    $error("pcm_sample: expected %0d, got %0d", want.pcm,
                           sample_out_ch.pcm_sample);
                    fail_count++;
                end
                if (sample_out_ch.voice_active !== want.active)
                begin
                    $error("voice_active: expected %0d, got %0d", want.active,
                           sample_out_ch.voice_active);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge clk)
    begin
        if ((sample_in_ch.valid && sample_in_ch.ready)
            || (sample_out_ch.valid && sample_out_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
        begin
            stall_cycles <= 0;
        end
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("timeout after %0d idle cycles, %0d items pending", stall_cycles,
                     pending_samples.size());
            $display("[tone_voice_with_envelope] ERROR");
            $finish;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial
    begin : stimulus
        stim_row_t directed_rows [0:N_DIRECTED-1];
        bit        after_item;
        int        rnd_mix;

        rst_n                   = 1'b0;
        sample_in_ch.valid      = 1'b0;
        sample_in_ch.mix_in     = '0;
        sample_in_ch.start_tone = 1'b0;
        cfg_ch.valid            = 1'b0;
        cfg_ch.index            = CFG_PHASE_STEP;
        cfg_ch.data             = '0;
        fail_count              = 0;
        samples_sent            = 0;
        results_seen            = 0;
        active_seen             = 0;
        settings_used           = 1;
        stall_cycles            = 0;

        for (int k = 0; k <= SINE_TABLE_DEPTH; k++)
        begin
            sine_q15[k] = quarter_sine(k);
        end
        r_step    = '0;
        r_amp     = '0;
        r_square  = 1'b0;
        r_len     = '0;
        r_attack  = RAMP_BITS'(220);
        r_release = RAMP_BITS'(661);
        v_count   = '1;
        v_phase   = '0;

        directed_rows = '{
            // idle after reset: pass-through and pcm scaling extremes
            known_sample(0, 1'b0, 0, 0, 1'b0),
            known_sample(524287, 1'b0, 524287, 32000, 1'b0),
            known_sample(-524288, 1'b0, -524288, -32000, 1'b0),
            known_sample(32768, 1'b0, 32768, 32000, 1'b0),
            known_sample(-32769, 1'b0, -32769, -32000, 1'b0),
            known_sample(2, 1'b0, 2, 1, 1'b0),
            known_sample(100, 1'b1, 100, 97, 1'b0),
            // full-scale square, no ramps, four samples long
            reg_write(CFG_PHASE_STEP, 32'd0),
            reg_write(CFG_AMPLITUDE, 32'd32768),
            reg_write(CFG_WAVE_SQUARE, 32'd1),
            reg_write(CFG_TONE_LENGTH, 32'd4),
            reg_write(CFG_ATTACK_LEN, 32'd0),
            reg_write(CFG_RELEASE_LEN, 32'd0),
            known_sample(0, 1'b1, 32768, 32000, 1'b1),
            known_sample(524287, 1'b0, 524287, 32000, 1'b1),
            known_sample(-524288, 1'b0, -491520, -32000, 1'b1),
            known_sample(0, 1'b0, 32768, 32000, 1'b1),
            known_sample(0, 1'b0, 0, 0, 1'b0),
            known_sample(-7, 1'b0, -7, -6, 1'b0),
            // quarter-turn steps reach the negative half of the square
            reg_write(CFG_PHASE_STEP, 32'h4000_0000),
            reg_write(CFG_TONE_LENGTH, 32'd6),
            plain_sample(0, 1'b1),
            plain_sample(0, 1'b0),
            known_sample(0, 1'b0, -32768, -32000, 1'b1),
            plain_sample(100, 1'b0),
            // sine at gain above one, longest tone, short attack, restart mid-tone
            reg_write(CFG_WAVE_SQUARE, 32'd0),
            reg_write(CFG_AMPLITUDE, 32'd65535),
            reg_write(CFG_TONE_LENGTH, 32'd1048575),
            reg_write(CFG_ATTACK_LEN, 32'd3),
            reg_write(CFG_RELEASE_LEN, 32'd65535),
            reg_write(CFG_PHASE_STEP, 32'hFFFF_FFFF),
            plain_sample(0, 1'b1),
            plain_sample(1000, 1'b0),
            plain_sample(300000, 1'b0),
            plain_sample(-300000, 1'b1),
            plain_sample(0, 1'b0),
            // longest attack over a three-sample tone
            reg_write(CFG_ATTACK_LEN, 32'd65535),
            reg_write(CFG_RELEASE_LEN, 32'd1),
            reg_write(CFG_TONE_LENGTH, 32'd3),
            plain_sample(0, 1'b1),
            plain_sample(0, 1'b0),
            plain_sample(0, 1'b0),
            plain_sample(0, 1'b0)
        };

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        after_item = 1'b0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_reg)
            begin
                if (after_item)
                begin
                    wait_idle();
                    settings_used++;
                end
                set_register(directed_rows[i].reg_idx, directed_rows[i].reg_data);
                after_item = 1'b0;
            end
            else
            begin
                send_sample(directed_rows[i]);
                after_item = 1'b1;
            end
        end

        for (int ph = 0; ph < N_PHASES; ph++)
        begin
            wait_idle();
            program_phase(ph);
            for (int n = 0; n < PHASE_SAMPLES; n++)
            begin
                if ($urandom_range(0, 3) == 0)
                begin
                    rnd_mix = $urandom;
                end
                else
                begin
                    rnd_mix = $urandom_range(0, 80000) - 40000;
                end
                send_sample(plain_sample(rnd_mix, (n == 0) || ($urandom_range(0, 39) == 0)));
            end
        end

        wait_idle();
        $display("%0d samples checked, %0d with the voice sounding", results_seen, active_seen);
        $display("%0d register settings, square and sine, ramps from zero to full length",
                 settings_used);
        if (fail_count == 0)
        begin
            $display("[tone_voice_with_envelope] OK");
        end
        else
        begin
            $display("[tone_voice_with_envelope] ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/tvwe_pkg.sv
design/tvwe_if.sv
design/tvwe_div.sv
design/tvwe_mul.sv
design/tone_voice_with_envelope.sv
design/tvwe_checker.sv
tb/testbench.sv
